>>> hdl/tsmq_pkg.sv
package tsmq_pkg;

  localparam int SCORE_W        = 24;
  localparam int MAX_CANDIDATES = 1024;
  localparam int POS_W          = $clog2(MAX_CANDIDATES);
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
  localparam int QUAL_W         = 8;
  localparam int DIV_W          = SCORE_W + QUAL_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int QBIT_W         = $clog2(QUAL_W);

  localparam logic [QUAL_W-1:0] MAX_QUALITY_RESET = QUAL_W'(60);
  localparam logic [POS_W-1:0]  POS_MAX           = POS_W'(MAX_CANDIDATES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX           = CNT_W'(MAX_CANDIDATES);

  // One finished read, handed from the tracker to the quality unit
  typedef struct packed {
    logic signed [SCORE_W-1:0] best;
    logic signed [SCORE_W-1:0] second;
    logic [CNT_W-1:0]          ties;
    logic [POS_W-1:0]          pos;
  } tsmq_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsmq_qsts_t;

endpackage

>>> hdl/tsmq_in_if.sv
interface tsmq_in_if;
  import tsmq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last;

  modport source (output valid, output score, output last, input ready);
  modport sink   (input valid, input score, input last, output ready);
endinterface

>>> hdl/tsmq_out_if.sv
interface tsmq_out_if;
  import tsmq_pkg::*;

  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] quality;
  logic [CNT_W-1:0]  equal_count;
  logic [POS_W-1:0]  best_index;

  modport source (output valid, output quality, output equal_count, output best_index,
                  input ready);
  modport sink   (input valid, input quality, input equal_count, input best_index,
                  output ready);
endinterface

>>> hdl/tsmq_front.sv
module tsmq_front (
  input  logic                clk,
  input  logic                rst_n,
  tsmq_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output tsmq_pkg::tsmq_rec_t push_rec
);
  import tsmq_pkg::*;

  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic signed [SCORE_W-1:0] second_r, second_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [CNT_W-1:0]          ties_r, ties_nxt;
  logic [POS_W-1:0]          item_r, item_nxt;
  logic                      accept;
  logic [CNT_W-1:0]          ties_bump;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ties_bump   = (ties_r < CNT_MAX) ? ties_r + CNT_W'(1) : ties_r;

  // Apply the tracking rule for the incoming score
  always_comb begin
    best_nxt   = best_r;
    second_nxt = second_r;
    pos_nxt    = pos_r;
    ties_nxt   = ties_r;
    if (in_ch.score > second_r) begin
      if (in_ch.score > best_r) begin
        second_nxt = best_r;
        best_nxt   = in_ch.score;
        pos_nxt    = item_r;
        ties_nxt   = CNT_W'(1);
      end else if (in_ch.score == best_r) begin
        ties_nxt   = ties_bump;
        second_nxt = best_r;
      end else begin
        second_nxt = in_ch.score;
      end
    end else if (in_ch.score == best_r) begin
      ties_nxt = ties_bump;
    end
    item_nxt = (item_r < POS_MAX) ? item_r + POS_W'(1) : item_r;
  end

  assign push            = accept && in_ch.last;
  assign push_rec.best   = best_nxt;
  assign push_rec.second = second_nxt;
  assign push_rec.ties   = ties_nxt;
  assign push_rec.pos    = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      best_r   <= '0;
      second_r <= '0;
      pos_r    <= '0;
      ties_r   <= '0;
      item_r   <= '0;
    end else if (accept) begin
      best_r   <= best_nxt;
      second_r <= second_nxt;
      pos_r    <= pos_nxt;
      ties_r   <= ties_nxt;
      item_r   <= item_nxt;
    end
  end
endmodule

>>> hdl/tsmq_queue.sv
module tsmq_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tsmq_pkg::tsmq_rec_t  push_rec,
  input  logic                 pop,
  output tsmq_pkg::tsmq_rec_t  head_rec,
  output tsmq_pkg::tsmq_qsts_t sts
);
  import tsmq_pkg::*;

  tsmq_rec_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign sts.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign sts.empty = (cnt_r == '0);
  assign head_rec  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end
endmodule

>>> hdl/tsmq_back.sv
module tsmq_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tsmq_pkg::QUAL_W-1:0] max_quality,
  input  logic                       q_empty,
  input  tsmq_pkg::tsmq_rec_t        head_rec,
  output logic                       pop,
  tsmq_out_if.source                 out_ch
);
  import tsmq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADJ  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_r;
  logic [SCORE_W-1:0]  div_r;
  logic [SCORE_W-1:0]  diff_r;
  logic                zero_r;
  logic [CNT_W-1:0]    ties_r;
  logic [POS_W-1:0]    pos_r;
  logic [DIV_W-1:0]    rem_r;
  logic [QUAL_W-1:0]   quo_r;
  logic [QBIT_W-1:0]   bit_r;
  logic                out_valid_r;
  logic [QUAL_W-1:0]   out_qual_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [POS_W-1:0]    out_pos_r;

  logic [DIV_W-1:0]    dvs_sh;
  logic [DIV_W:0]      trial;
  logic                load_out;

  assign dvs_sh   = {{QUAL_W{1'b0}}, div_r} << bit_r;
  assign trial    = {1'b0, rem_r} - {1'b0, dvs_sh};
  assign pop      = (state_r == S_IDLE) && !q_empty;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.quality     = out_qual_r;
  assign out_ch.equal_count = out_cnt_r;
  assign out_ch.best_index  = out_pos_r;

  // Payload and datapath registers of the read in flight, and the output payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        div_r  <= head_rec.best;
        diff_r <= head_rec.best - head_rec.second;
        zero_r <= (head_rec.best == '0);
        ties_r <= head_rec.ties;
        pos_r  <= head_rec.pos;
      end
      S_MUL: begin
        rem_r <= DIV_W'(max_quality) * DIV_W'(diff_r);
      end
      S_ADJ: begin
        rem_r <= rem_r + {{QUAL_W{1'b0}}, div_r} - DIV_W'(1);
        quo_r <= '0;
        bit_r <= QBIT_W'(QUAL_W - 1);
      end
      S_DIV: begin
        if (!trial[DIV_W]) begin
          rem_r        <= trial[DIV_W-1:0];
          quo_r[bit_r] <= 1'b1;
        end
        bit_r <= bit_r - QBIT_W'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_qual_r <= zero_r ? '0 : quo_r;
      out_cnt_r  <= ties_r;
      out_pos_r  <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (!q_empty) state_r <= S_MUL;
        S_MUL:  state_r <= S_ADJ;
        S_ADJ:  state_r <= zero_r ? S_DONE : S_DIV;
        S_DIV:  if (bit_r == '0) state_r <= S_DONE;
        S_DONE: if (load_out) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule

>>> hdl/top_two_score_mapping_quality.sv
// Mapping quality from the best and second-best candidate score of a read.
// Throughput: one score per cycle while the queue has room; the quality unit takes
// one read at a time: multiply, round-up add, one quotient bit per cycle for 8 bits
// (skipped when best is zero), then hand-off to the output register.
// Reset: rst_n synchronous, active low; clears the tracker, queue, quality unit and
// output valid, and sets max_quality to 60.
module top_two_score_mapping_quality (
  input  logic                        clk,
  input  logic                        rst_n,
  tsmq_in_if.sink                     in_ch,
  tsmq_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tsmq_pkg::QUAL_W-1:0] cfg_wdata
);
  import tsmq_pkg::*;

  // Scale register; the user must write it only while no read is in flight, unchecked
  logic [QUAL_W-1:0] max_quality_r;

  // Tracker to queue
  logic       push;
  tsmq_rec_t  push_rec;

  // Queue to quality unit
  logic       pop;
  tsmq_rec_t  head_rec;
  tsmq_qsts_t q_sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_quality_r <= MAX_QUALITY_RESET;
    end else if (cfg_we) begin
      max_quality_r <= cfg_wdata;
    end
  end

  // Front: compare each score against best and second, push the read on last.
  // It stalls the input only when the queue is full.
  tsmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_sts.full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Two finished reads can wait here, so short reads keep streaming while the
  // quality unit works through the previous one.
  tsmq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .sts      (q_sts)
  );

  // Back: quality = ceil(max_quality * (best - second) / best) via a
  // restoring divide, one quotient bit per cycle; held in an output register.
  tsmq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_quality (max_quality_r),
    .q_empty     (q_sts.empty),
    .head_rec    (head_rec),
    .pop         (pop),
    .out_ch      (out_ch)
  );
endmodule
